// File: rtl/core/mcma_pkg.sv
// Shared types and constants of the multichannel moving average unit.
`timescale 1ns / 1ps

package mcma_pkg;

  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned SAMPLE_W = 16;

  localparam logic signed [SAMPLE_W-1:0] AVG_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] AVG_MIN = 16'sh8000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } mcma_state_e;

  // Handshake between the sequencer and the bit-serial divider.
  typedef struct packed {
    logic start;
  } mcma_div_ctrl_t;

  typedef struct packed {
    logic done;
    logic busy;
  } mcma_div_stat_t;

endpackage

// File: rtl/core/multichannel_moving_average_unit.sv
// Top level of the multichannel moving average unit.
//
//  channel  direction  handshake               payload
//  input    in         in_valid_i/in_stall_o   channel_i, sample_i, sweep_end_i
//  output   out        out_valid_o/out_stall_i out_channel_o, average_o
//
// A transaction must be loaded into the output register before the next one
// can be accepted; the pace is set by the bit-serial divider, which produces
// one quotient bit per cycle. Channels out of range skip the divider.
// After reset a clearing pass writes zeros to the window store, one entry a cycle,
// and to the channel sums; no input is taken meanwhile.
// A finished result waits in the output register; a stalled output blocks the
// input only once a second result is ready.
`timescale 1ns / 1ps

module multichannel_moving_average_unit
  import mcma_pkg::*;
#(
  parameter int unsigned CHANNELS = 16,
  parameter int unsigned WINDOW   = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [CHAN_W-1:0]          channel_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       sweep_end_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [CHAN_W-1:0]          out_channel_o,
  output logic signed [SAMPLE_W-1:0] average_o
);

  localparam int unsigned STORE_DEPTH = CHANNELS * WINDOW;
  localparam int unsigned STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CH_AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned POS_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned DIV_W       = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W       = SAMPLE_W + $clog2(WINDOW);

  mcma_state_e state_q, state_d;

  logic [STORE_AW-1:0]       clr_cnt_q, clr_cnt_d;
  logic [POS_W-1:0]          pos_q, pos_d;
  logic                      warm_q, warm_d;

  logic [CHAN_W-1:0]         chan_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                      in_range_q;
  logic [POS_W-1:0]          pos_item_q;
  logic [DIV_W-1:0]          den_q;
  logic                      neg_q;

  logic                      out_valid_q, out_valid_d;
  logic [CHAN_W-1:0]         out_chan_q;
  logic signed [SAMPLE_W-1:0] out_avg_q;

  logic                      accept;
  logic                      in_range;
  logic                      out_free;
  logic                      out_load;
  logic                      clear_last;

  logic [STORE_AW-1:0]       slot;
  logic [CH_AW-1:0]          ch_idx;
  logic                      store_we;
  logic [STORE_AW-1:0]       store_waddr;
  logic [SAMPLE_W-1:0]       store_wdata;
  logic [SAMPLE_W-1:0]       store_rdata;
  logic                      sums_we;
  logic [CH_AW-1:0]          sums_waddr;
  logic [SUM_W-1:0]          sums_wdata;
  logic [SUM_W-1:0]          sums_rdata;

  logic signed [SUM_W-1:0]   new_sum;
  logic [SUM_W-1:0]          magnitude;
  logic [SUM_W-1:0]          quot;
  logic signed [SAMPLE_W-1:0] result;

  mcma_div_ctrl_t            div_ctrl;
  mcma_div_stat_t            div_stat;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = (32'(channel_i) < CHANNELS);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign clear_last = (clr_cnt_q == STORE_AW'(STORE_DEPTH - 1));

  assign ch_idx = CH_AW'(chan_q);
  assign slot   = STORE_AW'(32'(chan_q) * WINDOW + 32'(pos_item_q));

  // The old sum and the old slot value arrive together, in the cycle after the read.
  assign new_sum   = $signed(sums_rdata) + SUM_W'(sample_q) - SUM_W'($signed(store_rdata));
  assign magnitude = new_sum[SUM_W-1] ? SUM_W'(-new_sum) : SUM_W'(new_sum);

  always_comb begin
    result = '0;
    if (in_range_q) begin
      if (!neg_q) begin
        result = (quot > SUM_W'(32767)) ? AVG_MAX : $signed(quot[SAMPLE_W-1:0]);
      end else begin
        result = (quot > SUM_W'(32768)) ? AVG_MIN : -$signed(quot[SAMPLE_W-1:0]);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = in_range ? ST_READ : ST_DONE;
        end
      end
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_stat.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall_o     = 1'b1;
    store_we       = 1'b0;
    store_waddr    = slot;
    store_wdata    = sample_q;
    sums_we        = 1'b0;
    sums_waddr     = ch_idx;
    sums_wdata     = new_sum;
    div_ctrl.start = 1'b0;
    out_load       = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        store_we    = 1'b1;
        store_waddr = clr_cnt_q;
        store_wdata = '0;
        sums_we     = (32'(clr_cnt_q) < CHANNELS);
        sums_waddr  = CH_AW'(clr_cnt_q);
        sums_wdata  = '0;
      end
      ST_IDLE: in_stall_o = 1'b0;
      ST_UPDATE: begin
        store_we       = 1'b1;
        sums_we        = 1'b1;
        div_ctrl.start = 1'b1;
      end
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    if (state_q == ST_CLEAR) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
    end
  end

  // The shared window position moves on at acceptance of a transaction with sweep_end.
  always_comb begin
    pos_d  = pos_q;
    warm_d = warm_q;
    if (accept && sweep_end_i) begin
      if (pos_q == POS_W'(WINDOW - 1)) begin
        pos_d  = '0;
        warm_d = 1'b0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      pos_q       <= '0;
      warm_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      pos_q       <= pos_d;
      warm_q      <= warm_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      chan_q     <= channel_i;
      sample_q   <= sample_i;
      in_range_q <= in_range;
      pos_item_q <= pos_q;
      den_q      <= warm_q ? DIV_W'(32'(pos_q) + 1) : DIV_W'(WINDOW);
    end
    if (state_q == ST_UPDATE) begin
      neg_q <= new_sum[SUM_W-1];
    end
    if (out_load) begin
      out_chan_q <= chan_q;
      out_avg_q  <= result;
    end
  end

  mcma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (store_wdata),
    .raddr_i (slot),
    .rdata_o (store_rdata)
  );

  mcma_ram #(
    .WIDTH (SUM_W),
    .DEPTH (CHANNELS)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (sums_we),
    .waddr_i (sums_waddr),
    .wdata_i (sums_wdata),
    .raddr_i (ch_idx),
    .rdata_o (sums_rdata)
  );

  mcma_div #(
    .NUM_W (SUM_W),
    .DEN_W (DIV_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (magnitude),
    .den_i  (den_q),
    .stat_o (div_stat),
    .quot_o (quot)
  );

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_chan_q;
  assign average_o     = out_avg_q;

endmodule

// File: rtl/core/mcma_ram.sv
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps

module mcma_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mcma_div.sv
// Bit-serial restoring divider for unsigned operands, one quotient bit per cycle.
`timescale 1ns / 1ps

module mcma_div
  import mcma_pkg::*;
#(
  parameter int unsigned NUM_W = 19,
  parameter int unsigned DEN_W = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mcma_div_ctrl_t       ctrl_i,
  input  logic [NUM_W-1:0]     num_i,
  input  logic [DEN_W-1:0]     den_i,
  output mcma_div_stat_t       stat_o,
  output logic [NUM_W-1:0]     quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] shift_q, shift_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             qbit;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  assign trial = {rem_q, shift_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = (trial >= {1'b0, den_q});

  always_comb begin
    shift_d = shift_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (ctrl_i.start) begin
      shift_d = num_i;
      rem_d   = '0;
      den_d   = den_i;
      cnt_d   = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      shift_d = {shift_q[NUM_W-2:0], qbit};
      rem_d   = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
  end

  assign quot_o      = shift_q;
  assign stat_o.done = done_q;
  assign stat_o.busy = busy_q;

endmodule
